// File: rtl/arll_pkg.sv
// Shared types and constants for the audio reactive LED level block.
// Used by arll_ctrl, arll_dp and audio_reactive_led_level; no dependencies.
package arll_pkg;

	localparam int BUCKETS = 20;
	localparam int BW      = $clog2(BUCKETS);
	localparam int DW      = (BW > 5) ? BW : 5;

	localparam logic [2:0] CFG_FRAME_LENGTH  = 3'd0;
	localparam logic [2:0] CFG_WINDOW_LENGTH = 3'd1;
	localparam logic [2:0] CFG_GATE_LEVEL    = 3'd2;
	localparam logic [2:0] CFG_SILENCE_LIMIT = 3'd3;
	localparam logic [2:0] CFG_BUCKET_FRAMES = 3'd4;

	localparam logic [9:0] RST_FRAME_LENGTH  = 10'd500;
	localparam logic [4:0] RST_WINDOW_LENGTH = 5'd5;
	localparam logic [7:0] RST_GATE_LEVEL    = 8'd105;
	localparam logic [9:0] RST_SILENCE_LIMIT = 10'd5;
	localparam logic [7:0] RST_BUCKET_FRAMES = 8'd15;
	localparam logic [9:0] RST_FIRST_BUCKET  = 10'd11;
	localparam logic [2:0] RST_MASK          = 3'd5;
	localparam logic [2:0] MASK_ALL          = 3'd7;
	localparam logic [7:0] COLOR_HOLD        = 8'd7;

	// floor(x*17/10) == (x*891293) >> 19 for x up to 255
	localparam logic [27:0] SCALE_MUL   = 28'd891293;
	localparam int          SCALE_SHIFT = 19;

	typedef struct packed {
		logic [9:0] sample;
		logic [2:0] random_bits;
	} in_t;

	typedef struct packed {
		logic [7:0] red_duty;
		logic [7:0] green_duty;
		logic [7:0] blue_duty;
		logic [7:0] level;
		logic [2:0] color_mask;
		logic       silent;
	} out_t;

	typedef struct packed {
		logic take;
		logic fold;
		logic sweep;
		logic prep;
		logic div_step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic frame_end;
		logic sweep_done;
		logic div_done;
		logic out_full;
	} sts_t;

endpackage

// File: rtl/arll_ctrl.sv
// Sequencer for the LED level block: per-request sample intake and
// end-of-frame fold, ring sweep, divide and result steps. Uses arll_pkg.
module arll_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  arll_pkg::sts_t sts,
	output arll_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_FOLD,
		S_SWEEP,
		S_PREP,
		S_DIV,
		S_FINISH
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.take     = (state_q == S_IDLE) && in_valid;
		cmd.fold     = (state_q == S_FOLD);
		cmd.sweep    = (state_q == S_SWEEP);
		cmd.prep     = (state_q == S_PREP);
		cmd.div_step = (state_q == S_DIV);
		cmd.finish   = (state_q == S_FINISH) && !sts.out_full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && sts.frame_end) state_q <= S_FOLD;
				end
				S_FOLD:  state_q <= S_SWEEP;
				S_SWEEP: begin
					if (sts.sweep_done) state_q <= S_PREP;
				end
				S_PREP:  state_q <= S_DIV;
				S_DIV: begin
					if (sts.div_done) state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (!sts.out_full) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_frame_to_fold: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.take && sts.frame_end) |=> (state_q == S_FOLD))
		else $error("frame end did not start fold");

	a_fold_to_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FOLD) |=> (state_q == S_SWEEP))
		else $error("fold not followed by sweep");

	a_sweep_to_prep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SWEEP && sts.sweep_done) |=> (state_q == S_PREP))
		else $error("sweep end lost");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !sts.out_full)
		else $error("result written over a stalled one");

endmodule

// File: rtl/arll_dp.sv
// Datapath for the LED level block: config registers, frame peak, bucket
// ring, window/ring max sweep, restoring divider, gate/scale, colors.
// Uses arll_pkg; driven by arll_ctrl commands.
module arll_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  arll_pkg::in_t  in_data,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [2:0]     cfg_index,
	input  logic [9:0]     cfg_data,
	output logic           out_valid,
	input  logic           out_ready,
	output arll_pkg::out_t out_data,
	input  arll_pkg::cmd_t cmd,
	output arll_pkg::sts_t sts
);

	logic [9:0] frame_length_q;
	logic [4:0] window_length_q;
	logic [7:0] gate_level_q;
	logic [9:0] silence_limit_q;
	logic [7:0] bucket_frames_q;

	logic [9:0] peak_q;
	logic [9:0] sample_count_q;
	logic [2:0] rnd_q;
	logic [9:0] ring_q [arll_pkg::BUCKETS];
	logic [arll_pkg::BW-1:0] pos_q;
	logic [7:0] fc_q;
	logic [7:0] uc_q;
	logic [2:0] mask_q;
	logic [7:0] duty_q [3];

	logic [17:0] num_q;
	logic [arll_pkg::BW-1:0] idx_q;
	logic [arll_pkg::BW-1:0] d_q;
	logic [9:0] wmax_q;
	logic [9:0] rmax_q;
	logic [9:0] r_q;
	logic [7:0] nlo_q;
	logic [7:0] q_q;
	logic [2:0] dcnt_q;
	logic       zero_q;
	logic       ovf_q;

	logic       out_valid_q;
	arll_pkg::out_t out_q;

	logic [9:0] cnt_inc;
	logic [9:0] len;
	logic [9:0] new_peak;
	logic       adv;
	logic [arll_pkg::BW-1:0] pos_inc;
	logic [arll_pkg::BW-1:0] fold_pos;
	logic [arll_pkg::BW-1:0] idx_inc;
	logic [9:0] ring_val;
	logic       in_win;
	logic [10:0] div_t;
	logic       div_ge;
	logic [7:0] diff;
	logic [27:0] prod;
	logic [8:0] scaled;
	logic [7:0] lvl;
	logic       chg;
	logic [2:0] new_mask;
	logic [7:0] base_duty [3];
	logic [7:0] new_duty [3];

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		cnt_inc  = sample_count_q + 10'd1;
		len      = (frame_length_q == 10'd0) ? 10'd1 : frame_length_q;
		new_peak = (in_data.sample > peak_q) ? in_data.sample : peak_q;
		adv      = fc_q > bucket_frames_q;
		pos_inc  = (pos_q == arll_pkg::BW'(arll_pkg::BUCKETS - 1)) ? '0 :
			pos_q + arll_pkg::BW'(1);
		fold_pos = adv ? pos_inc : pos_q;
		idx_inc  = (idx_q == arll_pkg::BW'(arll_pkg::BUCKETS - 1)) ? '0 :
			idx_q + arll_pkg::BW'(1);
		ring_val = ring_q[idx_q];
		// offset -1 is the last step of the sweep
		in_win   = (d_q == arll_pkg::BW'(arll_pkg::BUCKETS - 1)) ||
			(arll_pkg::DW'(d_q) < arll_pkg::DW'(window_length_q));
		div_t    = {r_q, nlo_q[7]};
		div_ge   = div_t >= {1'b0, wmax_q};

		diff   = q_q - gate_level_q;
		prod   = {20'd0, diff} * arll_pkg::SCALE_MUL;
		scaled = prod[arll_pkg::SCALE_SHIFT +: 9];
		if (zero_q)                lvl = 8'd0;
		else if (ovf_q)            lvl = 8'd255;
		else if (q_q < gate_level_q) lvl = 8'd0;
		else if (scaled[8])        lvl = 8'd255;
		else                       lvl = scaled[7:0];

		chg      = (lvl == 8'd0) && (uc_q > arll_pkg::COLOR_HOLD);
		new_mask = chg ? ((rnd_q == 3'd0) ? arll_pkg::MASK_ALL : rnd_q) : mask_q;
		for (int i = 0; i < 3; i++) begin
			base_duty[i] = chg ? 8'd0 : duty_q[i];
			new_duty[i]  = new_mask[i] ? lvl : base_duty[i];
		end

		sts.frame_end  = cnt_inc >= len;
		sts.sweep_done = (d_q == arll_pkg::BW'(arll_pkg::BUCKETS - 1));
		sts.div_done   = (dcnt_q == 3'd7);
		sts.out_full   = out_valid_q && !out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_length_q  <= arll_pkg::RST_FRAME_LENGTH;
			window_length_q <= arll_pkg::RST_WINDOW_LENGTH;
			gate_level_q    <= arll_pkg::RST_GATE_LEVEL;
			silence_limit_q <= arll_pkg::RST_SILENCE_LIMIT;
			bucket_frames_q <= arll_pkg::RST_BUCKET_FRAMES;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				arll_pkg::CFG_FRAME_LENGTH:  frame_length_q  <= cfg_data;
				arll_pkg::CFG_WINDOW_LENGTH: window_length_q <= cfg_data[4:0];
				arll_pkg::CFG_GATE_LEVEL:    gate_level_q    <= cfg_data[7:0];
				arll_pkg::CFG_SILENCE_LIMIT: silence_limit_q <= cfg_data;
				arll_pkg::CFG_BUCKET_FRAMES: bucket_frames_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q         <= '0;
			sample_count_q <= '0;
			for (int j = 0; j < arll_pkg::BUCKETS; j++) begin
				ring_q[j] <= (j == 0) ? arll_pkg::RST_FIRST_BUCKET : 10'd0;
			end
			pos_q       <= '0;
			fc_q        <= '0;
			uc_q        <= '0;
			mask_q      <= arll_pkg::RST_MASK;
			for (int i = 0; i < 3; i++) begin
				duty_q[i] <= '0;
			end
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.take) begin
				peak_q         <= new_peak;
				sample_count_q <= cnt_inc;
			end
			if (cmd.fold) begin
				for (int j = 0; j < arll_pkg::BUCKETS; j++) begin
					if (adv && pos_inc == arll_pkg::BW'(j)) begin
						ring_q[j] <= '0;
					end else if (pos_q == arll_pkg::BW'(j) && ring_q[j] < peak_q) begin
						ring_q[j] <= peak_q;
					end
				end
				pos_q <= fold_pos;
				fc_q  <= (adv ? 8'd0 : fc_q) + 8'd1;
			end
			if (cmd.finish) begin
				uc_q   <= (chg ? 8'd0 : uc_q) + 8'd1;
				mask_q <= new_mask;
				for (int i = 0; i < 3; i++) begin
					duty_q[i] <= new_duty[i];
				end
				peak_q         <= '0;
				sample_count_q <= '0;
				out_valid_q    <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			rnd_q <= in_data.random_bits;
		end
		if (cmd.fold) begin
			num_q  <= {peak_q, 8'd0} - {8'd0, peak_q};
			idx_q  <= fold_pos;
			d_q    <= '0;
			wmax_q <= '0;
			rmax_q <= '0;
		end
		if (cmd.sweep) begin
			if (ring_val > rmax_q) rmax_q <= ring_val;
			if (in_win && ring_val > wmax_q) wmax_q <= ring_val;
			idx_q <= idx_inc;
			d_q   <= d_q + arll_pkg::BW'(1);
		end
		if (cmd.prep) begin
			zero_q <= (wmax_q == 10'd0);
			ovf_q  <= num_q >= {wmax_q, 8'd0};
			r_q    <= num_q[17:8];
			nlo_q  <= num_q[7:0];
			q_q    <= '0;
			dcnt_q <= '0;
		end
		if (cmd.div_step) begin
			r_q    <= div_ge ? 10'(div_t - {1'b0, wmax_q}) : div_t[9:0];
			q_q    <= {q_q[6:0], div_ge};
			nlo_q  <= {nlo_q[6:0], 1'b0};
			dcnt_q <= dcnt_q + 3'd1;
		end
		if (cmd.finish) begin
			out_q.red_duty   <= new_duty[0];
			out_q.green_duty <= new_duty[1];
			out_q.blue_duty  <= new_duty[2];
			out_q.level      <= lvl;
			out_q.color_mask <= new_mask;
			out_q.silent     <= rmax_q < silence_limit_q;
		end
	end

endmodule

// File: rtl/audio_reactive_led_level.sv
// Audio reactive LED level block, top level.
// Joins arll_ctrl and arll_dp; uses arll_pkg for payload types.
//
// Usage:
//   in_valid/in_ready/in_data carry one ADC sample and a random color mask
//   per request. Samples that do not close a frame are taken while the block stays idle.
//   The sample that closes a frame starts the end-of-frame work: a fold
//   step, a sweep over all 20 ring buckets (one bucket a cycle, giving the
//   window maximum and the ring maximum together), a setup step, an 8-step
//   restoring divide and a result step that loads the output register.
//   in_ready is low during that work.
//   out_valid/out_ready/out_data deliver one result per frame from a
//   register; the next frame's samples are taken while it waits. If a new
//   result is ready while the old one is still stalled, the block holds in
//   its result step until out_ready frees the register.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the five registers;
//   cfg_ready is always high, and writes are meant for idle periods.
//   Reset (arst_n low) restores default registers, clears the frame and the
//   ring (first bucket 11), sets the mask to red and blue, drops out_valid.
module audio_reactive_led_level (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  arll_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output arll_pkg::out_t out_data,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [2:0]     cfg_index,
	input  logic [9:0]     cfg_data
);

	arll_pkg::cmd_t cmd;
	arll_pkg::sts_t sts;

	arll_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	arll_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// File: bench/audio_reactive_led_level_chk.sv
`timescale 1ns / 1ps
// Checker for audio_reactive_led_level: watches the request, result and register channels,
// predicts each frame result and compares it field by field. Depends on arll_pkg.
module audio_reactive_led_level_chk (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_ready,
	input  arll_pkg::in_t  in_data,
	input  logic           out_valid,
	input  logic           out_ready,
	input  arll_pkg::out_t out_data,
	input  logic           cfg_valid,
	input  logic           cfg_ready,
	input  logic [2:0]     cfg_index,
	input  logic [9:0]     cfg_data,
	output int             pending,
	output int             errors
);

	logic [9:0] frame_len_reg;
	logic [4:0] window_reg;
	logic [7:0] gate_reg;
	logic [9:0] silence_reg;
	logic [7:0] bucket_frames_reg;

	logic [9:0] peak_now;
	logic [9:0] samples_seen;
	logic [9:0] bucket_pk [arll_pkg::BUCKETS];
	int         ring_pos;
	logic [7:0] frames_in_bucket;
	logic [7:0] updates;
	logic [2:0] mask_now;
	logic [7:0] duty [3];

	arll_pkg::out_t frame_results_q [$];

	initial errors = 0;

	task automatic report_mismatch(string msg);
		$display("%0t ns chk: %s", $realtime, msg);
		errors++;
	endtask

	task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
		end
	endtask

	function automatic int unsigned window_peak();
		int unsigned m;
		int idx;
		m = 0;
		for (int off = -1; off < int'(window_reg); off++) begin
			idx = (ring_pos + off + arll_pkg::BUCKETS) % arll_pkg::BUCKETS;
			if (bucket_pk[idx] > m) m = bucket_pk[idx];
		end
		return m;
	endfunction

	function automatic logic [7:0] scaled_level(int unsigned pk, int unsigned mx);
		int unsigned raw;
		int unsigned lv;
		if (mx == 0) return 8'd0;
		raw = (255 * pk) / mx;
		if (raw > 255) return 8'd255;
		if (raw < gate_reg) return 8'd0;
		lv = ((raw - gate_reg) * 17) / 10;
		return (lv > 255) ? 8'd255 : lv[7:0];
	endfunction

	task automatic take_sample(arll_pkg::in_t s);
		int unsigned frame_len;
		int unsigned ringmax;
		logic [7:0] lvl;
		arll_pkg::out_t r;
		frame_len = (frame_len_reg == 0) ? 1 : frame_len_reg;
		if (s.sample > peak_now) peak_now = s.sample;
		samples_seen = samples_seen + 10'd1;
		if (samples_seen < frame_len) return;

		if (bucket_pk[ring_pos] < peak_now) bucket_pk[ring_pos] = peak_now;
		if (frames_in_bucket > bucket_frames_reg) begin
			ring_pos = (ring_pos + 1) % arll_pkg::BUCKETS;
			bucket_pk[ring_pos] = '0;
			frames_in_bucket = '0;
		end
		frames_in_bucket = frames_in_bucket + 8'd1;

		lvl = scaled_level(peak_now, window_peak());
		if (lvl == 0 && updates > arll_pkg::COLOR_HOLD) begin
			mask_now = (s.random_bits == 0) ? arll_pkg::MASK_ALL : s.random_bits;
			for (int i = 0; i < 3; i++) duty[i] = '0;
			updates = '0;
		end
		updates = updates + 8'd1;
		for (int i = 0; i < 3; i++) begin
			if (mask_now[i]) duty[i] = lvl;
		end

		ringmax = 0;
		for (int i = 0; i < arll_pkg::BUCKETS; i++) begin
			if (bucket_pk[i] > ringmax) ringmax = bucket_pk[i];
		end

		r.red_duty   = duty[0];
		r.green_duty = duty[1];
		r.blue_duty  = duty[2];
		r.level      = lvl;
		r.color_mask = mask_now;
		r.silent     = (ringmax < silence_reg);
		frame_results_q.push_back(r);

		peak_now = '0;
		samples_seen = '0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_len_reg     = arll_pkg::RST_FRAME_LENGTH;
			window_reg        = arll_pkg::RST_WINDOW_LENGTH;
			gate_reg          = arll_pkg::RST_GATE_LEVEL;
			silence_reg       = arll_pkg::RST_SILENCE_LIMIT;
			bucket_frames_reg = arll_pkg::RST_BUCKET_FRAMES;
			peak_now          = '0;
			samples_seen      = '0;
			for (int i = 0; i < arll_pkg::BUCKETS; i++) bucket_pk[i] = '0;
			bucket_pk[0]      = arll_pkg::RST_FIRST_BUCKET;
			ring_pos          = 0;
			frames_in_bucket  = '0;
			updates           = '0;
			mask_now          = arll_pkg::RST_MASK;
			for (int i = 0; i < 3; i++) duty[i] = '0;
			frame_results_q.delete();
			pending           = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (frame_results_q.size() == 0) begin
					report_mismatch("result with no frame pending");
				end else begin
					check_field("red_duty", out_data.red_duty, frame_results_q[0].red_duty);
					check_field("green_duty", out_data.green_duty,
						frame_results_q[0].green_duty);
					check_field("blue_duty", out_data.blue_duty, frame_results_q[0].blue_duty);
					check_field("level", out_data.level, frame_results_q[0].level);
					check_field("color_mask", 8'(out_data.color_mask),
						8'(frame_results_q[0].color_mask));
					check_field("silent", 8'(out_data.silent), 8'(frame_results_q[0].silent));
					void'(frame_results_q.pop_front());
				end
			end
			if (in_valid && in_ready) take_sample(in_data);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					arll_pkg::CFG_FRAME_LENGTH:  frame_len_reg     = cfg_data;
					arll_pkg::CFG_WINDOW_LENGTH: window_reg        = cfg_data[4:0];
					arll_pkg::CFG_GATE_LEVEL:    gate_reg          = cfg_data[7:0];
					arll_pkg::CFG_SILENCE_LIMIT: silence_reg       = cfg_data;
					arll_pkg::CFG_BUCKET_FRAMES: bucket_frames_reg = cfg_data[7:0];
					default: ;
				endcase
			end
			pending = frame_results_q.size();
		end
	end

endmodule

// File: bench/audio_reactive_led_level_tb.sv
`timescale 1ns / 1ps
// Testbench top for audio_reactive_led_level: drives samples, register writes and result
// back-pressure; checking lives in audio_reactive_led_level_chk. Depends on arll_pkg.
module audio_reactive_led_level_tb;

	localparam int         DRAIN_CYCLES    = 40;
	localparam int         WATCHDOG_LIMIT  = 20000;
	localparam int         NUM_PHASES      = 9;
	localparam int         DIRECTED_PHASES = 2;
	localparam int         COL_ITEMS       = 5;
	localparam logic [2:0] CFG_SPARE       = 3'd7;

	logic           clk       = 1'b0;
	logic           arst_n    = 1'b0;
	logic           in_valid  = 1'b0;
	logic           in_ready;
	arll_pkg::in_t  in_data   = '0;
	logic           out_valid;
	logic           out_ready = 1'b0;
	arll_pkg::out_t out_data;
	logic           cfg_valid = 1'b0;
	logic           cfg_ready;
	logic [2:0]     cfg_index = '0;
	logic [9:0]     cfg_data  = '0;

	int pending;
	int errors;
	int quiet_cycles = 0;
	int sender_idle_pct = 28;
	int recv_idle_pct = 68;

	// frame_length, window_length, gate_level, silence_limit, bucket_frames, items
	int plan [NUM_PHASES][6] = '{
		'{0,    0,  0,   1023, 0,   12},
		'{1,    31, 255, 0,    255, 12},
		'{4,    5,  105, 5,    15,  220},
		'{1023, 20, 50,  100,  3,   150},
		'{3,    1,  0,   1023, 0,   220},
		'{2,    0,  200, 0,    255, 180},
		'{6,    31, 255, 512,  1,   200},
		'{1,    12, 30,  40,   2,   260},
		'{5,    20, 105, 5,    0,   260}
	};

	int dir_samples [12] = '{1023, 0, 1, 512, 1023, 768, 1023, 1023, 0, 0, 0, 1};

	audio_reactive_led_level dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	audio_reactive_led_level_chk chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pending   (pending),
		.errors    (errors)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("audio_reactive_led_level_tb: FAIL");
				$finish;
			end
		end
	end

	task automatic write_reg(logic [2:0] idx, int value);
		logic [9:0] junk;
		case (idx)
			arll_pkg::CFG_WINDOW_LENGTH: junk = 10'($urandom_range(0, 31)) << 5;
			arll_pkg::CFG_GATE_LEVEL, arll_pkg::CFG_BUCKET_FRAMES:
				junk = 10'($urandom_range(0, 3)) << 8;
			default:                     junk = '0;
		endcase
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= 10'(value) | junk;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	// registers change only once every frame result is out and the block has settled
	task automatic configure(int p);
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		for (int idx = arll_pkg::CFG_FRAME_LENGTH; idx <= arll_pkg::CFG_BUCKET_FRAMES;
			idx++) begin
			write_reg(idx[2:0], plan[p][idx]);
		end
		if (p == 0) write_reg(CFG_SPARE, $urandom_range(0, 1023));
		cfg_valid <= 1'b0;
	endtask

	task automatic send_sample(arll_pkg::in_t d, bit hold);
		if (hold) begin
			in_valid <= 1'b0;
			@(negedge clk);
			while (pending != 0) @(negedge clk);
		end else if ($urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
			while ($urandom_range(0, 99) < sender_idle_pct) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= d;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	initial begin
		arll_pkg::in_t item;
		int  amp;
		bit  hold;
		amp = 1023;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p < 3) begin
				sender_idle_pct = 28;
				recv_idle_pct   = 68;
			end else if (p < 6) begin
				sender_idle_pct = 68;
				recv_idle_pct   = 28;
			end else begin
				sender_idle_pct = 0;
				recv_idle_pct   = 0;
			end
			configure(p);
			for (int k = 0; k < plan[p][COL_ITEMS]; k++) begin
				if (p < DIRECTED_PHASES) begin
					item.sample      = 10'(dir_samples[k]);
					item.random_bits = k[2:0];
					hold = 1'b0;
				end else begin
					// loudness drifts between silence, quiet and full scale
					if ($urandom_range(0, 15) == 0) begin
						case ($urandom_range(0, 4))
							0:       amp = 0;
							1:       amp = 7;
							2:       amp = 63;
							3:       amp = 511;
							default: amp = 1023;
						endcase
					end
					item.sample      = 10'($urandom_range(0, amp));
					item.random_bits = 3'($urandom_range(0, 7));
					hold = ($urandom_range(0, 49) == 0) || (p == DIRECTED_PHASES && k == 20);
				end
				send_sample(item, hold);
			end
		end

		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0) begin
			$display("audio_reactive_led_level_tb: PASS");
		end else begin
			$display("audio_reactive_led_level_tb: FAIL");
		end
		$finish;
	end

endmodule
